// ===== rtl/hashed_set_union_intersect_diff_macros.svh =====
// Assertion macros shared by the hashed set block.
// Depends on nothing; included by modules that assert.
`ifndef HASHED_SET_UNION_INTERSECT_DIFF_MACROS_SVH
`define HASHED_SET_UNION_INTERSECT_DIFF_MACROS_SVH
// Implication checked every clock outside reset.
`define HS_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HS_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/hsuid_pkg.sv =====
// Package for the hashed set block: request codes, status codes, queue entry type.
// Depends on nothing.
`timescale 1ns / 1ps
package hsuid_pkg;
   localparam int KEY_W = 31;
   localparam logic [2:0] REQ_INS_A = 3'd0;
   localparam logic [2:0] REQ_INS_B = 3'd1;
   localparam logic [2:0] REQ_UNION = 3'd2;
   localparam logic [2:0] REQ_INTER = 3'd3;
   localparam logic [2:0] REQ_DIFF  = 3'd4;
   localparam logic [2:0] REQ_CLEAR = 3'd5;
   localparam logic [1:0] ST_ADDED = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam int MAX_RESULTS = 32;

   typedef enum logic [2:0] {
      OP_INSERT = 3'b001,
      OP_EMIT   = 3'b010,
      OP_PLAIN  = 3'b100
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              set_b;   // insert target, or first set for emit
      logic [2:0]        req;
      logic [KEY_W-1:0]  key;
   } cmd_type;
endpackage

// ===== rtl/hashed_set_union_intersect_diff.sv =====
// Top level of the hashed set union / intersection / difference block.
// Depends on hsuid_pkg, hsuid_front and hsuid_back.
`timescale 1ns / 1ps
// Usage:
// Request beats arrive on the req_ channel (valid/ready). Insert requests
// add a key to set A or B and answer with one beat carrying a status.
// Union, intersection and difference requests stream one beat per member,
// in insertion order, with rsp_last on the final beat; an empty answer is a
// single beat with rsp_empty_result set. Clear empties both sets.
// Flow: the front queue holds two requests, so the
// sender can run ahead of the back end. An insert computes the home slot,
// probes slots until it finds the key, a free slot or has tried them all,
// writes the key when it is added, and then answers. An emit reads each
// order list entry it walks, computes its home slot, probes the other
// set's table, and sends a beat for each member kept. The speed is set by
// the serial walk and the single-port slot table RAMs, read one slot at a
// time, and the home slot is computed in S_HASH and S_HOME per probed key.
// Reset clears the counts and the used bits directly; no sweep is
// needed. When the receiver stalls, the result beat holds and the walk
// pauses; the front keeps accepting until its queue is full.
module hashed_set_union_intersect_diff
   import hsuid_pkg::*;
#(
   parameter int SET_CAPACITY = 16,
   parameter int TABLE_SLOTS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [KEY_W-1:0] req_key,
   input  logic             req_first_is_b,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [KEY_W-1:0] rsp_result_key,
   output logic             rsp_key_valid,
   output logic             rsp_empty_result,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   // Command queue between the classifying front and the executing back.
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   hsuid_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_key,
      .req_first_is_b, .cmd_valid, .cmd_ready, .cmd
   );

   hsuid_back #(.SET_CAPACITY(SET_CAPACITY), .TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .rsp_valid, .rsp_ready,
      .rsp_result_key, .rsp_key_valid, .rsp_empty_result, .rsp_status, .rsp_last
   );
endmodule

// ===== rtl/hsuid_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module hsuid_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

// ===== rtl/hsuid_front.sv =====
// Front end: accepts request beats, classifies them, queues commands.
// Depends on hsuid_pkg.
`timescale 1ns / 1ps
module hsuid_front
   import hsuid_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [KEY_W-1:0] req_key,
   input  logic             req_first_is_b,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cmd_type          cmd
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   cmd_type    c;
   logic       push, pop;

   always_comb begin
      c.req   = req_type;
      c.key   = req_key;
      c.set_b = (req_type == REQ_INS_B) || req_first_is_b;
      unique case (req_type)
         REQ_INS_A, REQ_INS_B:            c.op = OP_INSERT;
         REQ_UNION, REQ_INTER, REQ_DIFF:  c.op = OP_EMIT;
         default:                         c.op = OP_PLAIN;
      endcase
      if (req_type == REQ_INS_A) c.set_b = 1'b0;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rp_ff];
   assign wp_in     = wp_ff ^ push;
   assign rp_in     = rp_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end
endmodule

// ===== rtl/hsuid_back.sv =====
// Back end: probes the two tables, walks the order lists, drives result beats.
// Depends on hsuid_pkg, hsuid_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "hashed_set_union_intersect_diff_macros.svh"
module hsuid_back
   import hsuid_pkg::*;
#(
   parameter int SET_CAPACITY = 16,
   parameter int TABLE_SLOTS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [KEY_W-1:0] rsp_result_key,
   output logic             rsp_key_valid,
   output logic             rsp_empty_result,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int OW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CW = $clog2(SET_CAPACITY + 1);
   localparam int PW = $clog2(TABLE_SLOTS + 1);
   localparam int NW = $clog2(MAX_RESULTS + 1);
   localparam logic [SW-1:0] SLOT_MAX = SW'(TABLE_SLOTS - 1);
   // Home slot by reciprocal multiplication: quotient = (key * HASH_M) >> HASH_K,
   // exact for every key below 2**KEY_W.
   localparam int HASH_K = KEY_W + SW;
   localparam logic [63:0] HASH_M =
      ((64'd1 << HASH_K) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_PRB_RD = 11'b00000000010,  // slot read issued, wait for the data
      S_PRB_CK = 11'b00000000100,  // compare slot key
      S_ORD_RD = 11'b00000001000,  // order list read issued
      S_ORD_CK = 11'b00000010000,  // order key now available
      S_OUT    = 11'b00000100000,  // result beat pending
      S_CLEAR  = 11'b00001000000,
      S_INS_WR = 11'b00010000000,
      S_NEXT   = 11'b00100000000,
      S_HASH   = 11'b01000000000,  // quotient of the probed key
      S_HOME   = 11'b10000000000   // home slot from the remainder
   } state_type;

   state_type         st_ff, st_in;
   cmd_type           cmd_ff;
   logic              phase2_ff;   // union second pass
   logic [CW-1:0]     cnt_a_ff, cnt_b_ff;
   logic [CW-1:0]     idx_ff;
   logic [NW-1:0]     nout_ff;
   logic [SW-1:0]     slot_ff;
   logic [PW-1:0]     steps_ff;
   logic [KEY_W-1:0]  pkey_ff;     // key being probed
   logic [KEY_W-1:0]  hq_ff;       // key divided by the table size
   logic              probe_b_ff;  // table being probed
   logic [TABLE_SLOTS-1:0] used_a_ff, used_b_ff;
   logic [KEY_W-1:0]  o_key_ff;
   logic              o_kv_ff, o_em_ff, o_last_ff;
   logic [1:0]        o_st_ff;

   logic              ta_we, tb_we, oa_we, ob_we;
   logic [KEY_W-1:0]  ta_rd, tb_rd, oa_rd, ob_rd;
   logic [OW-1:0]     oaddr;

   hsuid_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_ta (.clock(clock), .wr_en(ta_we),
      .addr(slot_ff), .wr_data(pkey_ff), .rd_data(ta_rd));
   hsuid_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_tb (.clock(clock), .wr_en(tb_we),
      .addr(slot_ff), .wr_data(pkey_ff), .rd_data(tb_rd));
   hsuid_ram #(.WIDTH(KEY_W), .DEPTH(SET_CAPACITY)) u_oa (.clock(clock), .wr_en(oa_we),
      .addr(oaddr), .wr_data(pkey_ff), .rd_data(oa_rd));
   hsuid_ram #(.WIDTH(KEY_W), .DEPTH(SET_CAPACITY)) u_ob (.clock(clock), .wr_en(ob_we),
      .addr(oaddr), .wr_data(pkey_ff), .rd_data(ob_rd));

   logic ins_st;
   assign ins_st = (st_ff == S_INS_WR);
   assign ta_we  = ins_st && !cmd_ff.set_b;
   assign tb_we  = ins_st &&  cmd_ff.set_b;
   assign oa_we  = ta_we;
   assign ob_we  = tb_we;
   assign oaddr  = ins_st ? (cmd_ff.set_b ? cnt_b_ff[OW-1:0] : cnt_a_ff[OW-1:0])
                          : idx_ff[OW-1:0];

   // Current list being walked and the table it is checked against.
   logic             walk_b;
   logic [CW-1:0]    walk_cnt;
   logic [KEY_W-1:0] okey, skey;
   logic             sused;
   assign walk_b   = cmd_ff.set_b ^ phase2_ff;
   assign walk_cnt = walk_b ? cnt_b_ff : cnt_a_ff;
   assign okey     = walk_b ? ob_rd : oa_rd;
   assign skey     = probe_b_ff ? tb_rd : ta_rd;
   assign sused    = probe_b_ff ? used_b_ff[slot_ff] : used_a_ff[slot_ff];

   logic [63:0]      hprod;
   logic [KEY_W-1:0] hrem;
   assign hprod = {{(64 - KEY_W){1'b0}}, pkey_ff} * HASH_M;
   assign hrem  = pkey_ff - KEY_W'(hq_ff * KEY_W'(TABLE_SLOTS));

   assign cmd_ready        = (st_ff == S_IDLE);
   assign rsp_valid        = (st_ff == S_OUT);
   assign rsp_result_key   = o_key_ff;
   assign rsp_key_valid    = o_kv_ff;
   assign rsp_empty_result = o_em_ff;
   assign rsp_status       = o_st_ff;
   assign rsp_last         = o_last_ff;

   logic [SW-1:0] slot_nx;
   assign slot_nx = (slot_ff == SLOT_MAX) ? '0 : slot_ff + 1'b1;

   // Membership decision for emit: keep key after probe outcome "found".
   function automatic logic keep_it(input logic [2:0] r, input logic ph2,
                                    input logic found);
      if (r == REQ_UNION) return ph2 ? !found : 1'b1;
      if (r == REQ_INTER) return found;
      return !found;
   endfunction

   logic pending_ff;  // emit: a member was found, not yet taken into the hold
   // The newest member waits in a hold register until the next member is found
   // or the walk ends, so that the last flag rides on the final member beat.
   logic             hold_ff;
   logic [KEY_W-1:0] hkey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
         used_a_ff <= '0;
         used_b_ff <= '0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            S_IDLE: if (cmd_valid) begin
               cmd_ff    <= cmd;
               phase2_ff <= 1'b0;
               idx_ff    <= '0;
               nout_ff   <= '0;
               pkey_ff   <= cmd.key;
               probe_b_ff <= cmd.set_b;
               steps_ff  <= '0;
               pending_ff <= 1'b0;
               hold_ff   <= 1'b0;
            end
            S_HASH: hq_ff <= KEY_W'(hprod >> HASH_K);
            S_HOME: slot_ff <= hrem[SW-1:0];
            S_PRB_RD: ;
            S_PRB_CK: begin
               if (!sused || skey == pkey_ff) begin
                  if (cmd_ff.op == OP_INSERT) begin
                     o_key_ff <= '0; o_kv_ff <= 1'b0; o_em_ff <= 1'b0;
                     o_last_ff <= 1'b1;
                     if (sused) o_st_ff <= ST_DUP;
                     else if ((cmd_ff.set_b ? cnt_b_ff : cnt_a_ff) >= CW'(SET_CAPACITY))
                        o_st_ff <= ST_FULL;
                     else o_st_ff <= ST_ADDED;
                  end else begin
                     pending_ff <= keep_it(cmd_ff.req, phase2_ff, sused);
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else if (steps_ff == PW'(TABLE_SLOTS - 1)) begin
                  if (cmd_ff.op == OP_INSERT) begin
                     o_key_ff <= '0; o_kv_ff <= 1'b0; o_em_ff <= 1'b0;
                     o_last_ff <= 1'b1; o_st_ff <= ST_FULL;
                  end else begin
                     pending_ff <= keep_it(cmd_ff.req, phase2_ff, 1'b0);
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  slot_ff  <= slot_nx;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_INS_WR: begin
               if (cmd_ff.set_b) begin
                  used_b_ff[slot_ff] <= 1'b1;
                  cnt_b_ff <= cnt_b_ff + 1'b1;
               end else begin
                  used_a_ff[slot_ff] <= 1'b1;
                  cnt_a_ff <= cnt_a_ff + 1'b1;
               end
            end
            S_ORD_RD: ;
            S_ORD_CK: begin
               pkey_ff    <= okey;
               probe_b_ff <= !walk_b;
               steps_ff   <= '0;
            end
            S_NEXT: begin
               // Take a new member into the hold, advance, or finish.
               if (pending_ff) begin
                  if (hold_ff) begin
                     o_key_ff <= hkey_ff; o_kv_ff <= 1'b1; o_em_ff <= 1'b0;
                     o_st_ff <= ST_ADDED; o_last_ff <= 1'b0;
                  end
                  hkey_ff <= pkey_ff;
                  hold_ff <= 1'b1;
                  nout_ff <= nout_ff + 1'b1;
                  pending_ff <= 1'b0;
               end else if (idx_ff < walk_cnt && nout_ff < NW'(MAX_RESULTS)) begin
                  ;  // read issued by next state
               end else if (cmd_ff.req == REQ_UNION && !phase2_ff &&
                            nout_ff < NW'(MAX_RESULTS)) begin
                  phase2_ff <= 1'b1;
                  idx_ff <= '0;
               end else begin
                  o_key_ff <= hold_ff ? hkey_ff : '0; o_kv_ff <= hold_ff;
                  o_st_ff <= ST_ADDED;
                  o_em_ff <= !hold_ff; o_last_ff <= 1'b1;
               end
            end
            S_OUT: if (rsp_ready && !o_last_ff) begin
               ;
            end
            S_CLEAR: begin
               if (cmd_ff.req == REQ_CLEAR) begin
                  cnt_a_ff <= '0; cnt_b_ff <= '0;
                  used_a_ff <= '0; used_b_ff <= '0;
               end
               o_key_ff <= '0; o_kv_ff <= 1'b0; o_em_ff <= 1'b0;
               o_st_ff <= ST_ADDED; o_last_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (cmd_valid) begin
            unique case (cmd.op)
               OP_INSERT: st_in = S_HASH;
               OP_EMIT:   st_in = S_NEXT;
               default:   st_in = S_CLEAR;
            endcase
         end
         S_HASH:   st_in = S_HOME;
         S_HOME:   st_in = S_PRB_RD;
         S_PRB_RD: st_in = S_PRB_CK;
         S_PRB_CK: begin
            if (!sused || skey == pkey_ff || steps_ff == PW'(TABLE_SLOTS - 1)) begin
               if (cmd_ff.op == OP_INSERT)
                  st_in = (!sused && (cmd_ff.set_b ? cnt_b_ff : cnt_a_ff)
                           < CW'(SET_CAPACITY)) ? S_INS_WR : S_OUT;
               else st_in = S_NEXT;
            end else st_in = S_PRB_RD;
         end
         S_INS_WR: st_in = S_OUT;
         S_ORD_RD: st_in = S_ORD_CK;
         S_ORD_CK: st_in = S_HASH;
         S_NEXT: begin
            if (pending_ff) st_in = hold_ff ? S_OUT : S_NEXT;
            else if (idx_ff < walk_cnt && nout_ff < NW'(MAX_RESULTS)) st_in = S_ORD_RD;
            else if (cmd_ff.req == REQ_UNION && !phase2_ff &&
                     nout_ff < NW'(MAX_RESULTS)) st_in = S_NEXT;
            else st_in = S_OUT;
         end
         S_OUT: if (rsp_ready) st_in = o_last_ff ? S_IDLE : S_NEXT;
         S_CLEAR: st_in = S_OUT;
         default: st_in = S_IDLE;
      endcase
   end

   `HS_ASSERT_IMP(a_out_hold, clock, reset, rsp_valid && !rsp_ready, st_in == S_OUT,
      "result beat dropped under stall")
   `HS_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1,
      cnt_a_ff <= CW'(SET_CAPACITY) && cnt_b_ff <= CW'(SET_CAPACITY),
      "set count beyond capacity")
   `HS_ASSERT_NXT(a_clear, clock, reset, st_ff == S_CLEAR && cmd_ff.req == REQ_CLEAR,
      cnt_a_ff == '0 && cnt_b_ff == '0, "clear left a count")
endmodule
